// ===== hdl/psag_pkg.sv =====
`timescale 1ns / 1ps
// Package for the projective source address generator.
// Holds register indexes, field widths and the divider flag type; no dependencies.
package psag_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int COORD_W   = 12;
    // Magnitude of a 16.16 value shifted up by the fraction width.
    localparam int QUO_W     = COEF_W + FRAC_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int DIM_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ROW_SCALES    = 3'd0,
        REG_Y_ROW_SCALES    = 3'd1,
        REG_Z_ROW_SCALES    = 3'd2,
        REG_XY_OFFSETS      = 3'd3,
        REG_Z_OFFSET        = 3'd4,
        REG_ORIGIN_OFFSETS  = 3'd5,
        REG_SOURCE_GEOMETRY = 3'd6,
        REG_SOURCE_BASE     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic last;
        logic bad_x;
        logic bad_y;
    } psag_flags_t;

endpackage

// ===== hdl/psag_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed divider for two numerators sharing one divisor.
// One quotient bit per stage; depends on psag_pkg.
module psag_div import psag_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              in_last,
    input  logic [COEF_W-1:0] num_x,
    input  logic [COEF_W-1:0] num_y,
    input  logic [COEF_W-1:0] den,
    output logic              out_valid,
    output logic [COEF_W-1:0] quo_x,
    output logic [COEF_W-1:0] quo_y,
    output psag_flags_t       out_flags
);

    logic              v_reg    [0:QUO_W];
    logic              last_reg [0:QUO_W];
    logic              zero_reg [0:QUO_W];
    logic              negx_reg [0:QUO_W];
    logic              negy_reg [0:QUO_W];
    logic [COEF_W-1:0] d_reg    [0:QUO_W];
    logic [COEF_W-1:0] remx_reg [0:QUO_W];
    logic [COEF_W-1:0] remy_reg [0:QUO_W];
    logic [QUO_W-1:0]  nx_reg   [0:QUO_W];
    logic [QUO_W-1:0]  ny_reg   [0:QUO_W];
    logic [QUO_W-1:0]  qx_reg   [0:QUO_W];
    logic [QUO_W-1:0]  qy_reg   [0:QUO_W];

    logic              ov_reg;
    logic [COEF_W-1:0] qox_reg;
    logic [COEF_W-1:0] qoy_reg;
    psag_flags_t       fl_reg;

    function automatic logic [COEF_W-1:0] magnitude(input logic [COEF_W-1:0] v);
        magnitude = v[COEF_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Restoring step: returns {quotient bit, new remainder}.
    function automatic logic [COEF_W:0] div_step(input logic [COEF_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [COEF_W-1:0] d);
        logic [COEF_W:0] trial;
        trial = {rem, bit_in} - {1'b0, d};
        if (trial[COEF_W]) begin
            div_step = {1'b0, rem[COEF_W-2:0], bit_in};
        end else begin
            div_step = {1'b1, trial[COEF_W-1:0]};
        end
    endfunction

    // Applies the sign and checks the signed 32-bit range: returns {bad, quotient}.
    function automatic logic [COEF_W:0] sign_fix(input logic neg, input logic [QUO_W-1:0] q);
        logic ovf;
        if (neg) begin
            ovf = (|q[QUO_W-1:COEF_W]) || (q[COEF_W-1] && (|q[COEF_W-2:0]));
            sign_fix = {ovf, ~q[COEF_W-1:0] + 1'b1};
        end else begin
            ovf = |q[QUO_W-1:COEF_W-1];
            sign_fix = {ovf, q[COEF_W-1:0]};
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            last_reg[0] <= in_last;
            zero_reg[0] <= (den == '0);
            negx_reg[0] <= num_x[COEF_W-1] ^ den[COEF_W-1];
            negy_reg[0] <= num_y[COEF_W-1] ^ den[COEF_W-1];
            d_reg[0]    <= magnitude(den);
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
            nx_reg[0]   <= {magnitude(num_x), {FRAC_BITS{1'b0}}};
            ny_reg[0]   <= {magnitude(num_y), {FRAC_BITS{1'b0}}};
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [COEF_W:0] stepx_next;
        logic [COEF_W:0] stepy_next;

        always_comb begin
            stepx_next = div_step(remx_reg[k], nx_reg[k][QUO_W-1], d_reg[k]);
            stepy_next = div_step(remy_reg[k], ny_reg[k][QUO_W-1], d_reg[k]);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (en) begin
                last_reg[k+1] <= last_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                d_reg[k+1]    <= d_reg[k];
                remx_reg[k+1] <= stepx_next[COEF_W-1:0];
                remy_reg[k+1] <= stepy_next[COEF_W-1:0];
                nx_reg[k+1]   <= {nx_reg[k][QUO_W-2:0], 1'b0};
                ny_reg[k+1]   <= {ny_reg[k][QUO_W-2:0], 1'b0};
                qx_reg[k+1]   <= {qx_reg[k][QUO_W-2:0], stepx_next[COEF_W]};
                qy_reg[k+1]   <= {qy_reg[k][QUO_W-2:0], stepy_next[COEF_W]};
            end
        end
    end

    logic [COEF_W:0] fixx_next;
    logic [COEF_W:0] fixy_next;

    always_comb begin
        fixx_next = sign_fix(negx_reg[QUO_W], qx_reg[QUO_W]);
        fixy_next = sign_fix(negy_reg[QUO_W], qy_reg[QUO_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= v_reg[QUO_W];
        end
        if (en) begin
            qox_reg      <= fixx_next[COEF_W-1:0];
            qoy_reg      <= fixy_next[COEF_W-1:0];
            fl_reg.last  <= last_reg[QUO_W];
            fl_reg.bad_x <= zero_reg[QUO_W] | fixx_next[COEF_W];
            fl_reg.bad_y <= zero_reg[QUO_W] | fixy_next[COEF_W];
        end
    end

    assign out_valid = ov_reg;
    assign quo_x     = qox_reg;
    assign quo_y     = qoy_reg;
    assign out_flags = fl_reg;

endmodule

// ===== hdl/projective_source_address_gen.sv =====
`timescale 1ns / 1ps
// Projective source address generator, top level.
// Uses psag_pkg and the pipelined divider psag_div.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata: dst_x[11:0], dst_y[23:12]; tlast: span_last
//  m_axis   | out       | tdata: source_address[31:0]; tuser: pixel_valid; tlast: span_end
//  cfg      | in        | cfg_index (register), cfg_data (value), always ready
//
// One item per cycle is accepted while the output is not stalled; the divider
// resolves one quotient bit per stage. The whole pipeline advances when the
// output register is empty or taken, so a stall freezes every stage. Reset clears
// the valid bits and loads the configuration registers with their defaults.
module projective_source_address_gen import psag_pkg::*; #(
    parameter int MAX_SIZE     = 4096,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // dst_x[11:0], dst_y[23:12]
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // source_address[31:0]
    output logic [0:0]           m_axis_tuser,   // pixel_valid[0]
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_SIZE);

    logic [63:0] xrow_reg, yrow_reg, zrow_reg, xyoff_reg, origin_reg;
    logic [31:0] zoff_reg, base_reg;
    logic [47:0] geom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xrow_reg   <= 64'd65536;
            yrow_reg   <= 64'd281474976710656;
            zrow_reg   <= '0;
            xyoff_reg  <= '0;
            zoff_reg   <= 32'd65536;
            origin_reg <= '0;
            geom_reg   <= '0;
            base_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_X_ROW_SCALES:    xrow_reg   <= cfg_data;
                REG_Y_ROW_SCALES:    yrow_reg   <= cfg_data;
                REG_Z_ROW_SCALES:    zrow_reg   <= cfg_data;
                REG_XY_OFFSETS:      xyoff_reg  <= cfg_data;
                REG_Z_OFFSET:        zoff_reg   <= cfg_data[31:0];
                REG_ORIGIN_OFFSETS:  origin_reg <= cfg_data;
                REG_SOURCE_GEOMETRY: geom_reg   <= cfg_data[47:0];
                REG_SOURCE_BASE:     base_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic en;
    logic mv_reg;
    assign en            = !mv_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: input capture.
    logic               v0_reg, last0_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg;

    // Stage 1: six products, each wrapping at 32 bits.
    logic        v1_reg, last1_reg;
    logic [31:0] pa_reg, pb_reg, pd_reg, pe_reg, pg_reg, ph_reg;

    // Stage 2: projected sums.
    logic        v2_reg, last2_reg;
    logic [31:0] sx_reg, sy_reg, sz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
        if (en) begin
            x0_reg    <= s_axis_tdata[11:0];
            y0_reg    <= s_axis_tdata[23:12];
            last0_reg <= s_axis_tlast;
            pa_reg    <= xrow_reg[31:0]  * 32'(x0_reg);
            pb_reg    <= xrow_reg[63:32] * 32'(y0_reg);
            pd_reg    <= yrow_reg[31:0]  * 32'(x0_reg);
            pe_reg    <= yrow_reg[63:32] * 32'(y0_reg);
            pg_reg    <= zrow_reg[31:0]  * 32'(x0_reg);
            ph_reg    <= zrow_reg[63:32] * 32'(y0_reg);
            last1_reg <= last0_reg;
            sx_reg    <= pa_reg + pb_reg + xyoff_reg[31:0];
            sy_reg    <= pd_reg + pe_reg + xyoff_reg[63:32];
            sz_reg    <= pg_reg + ph_reg + zoff_reg;
            last2_reg <= last1_reg;
        end
    end

    logic        dv;
    logic [31:0] qx, qy;
    psag_flags_t dfl;

    psag_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_last   (last2_reg),
        .num_x     (sx_reg),
        .num_y     (sy_reg),
        .den       (sz_reg),
        .out_valid (dv),
        .quo_x     (qx),
        .quo_y     (qy),
        .out_flags (dfl)
    );

    // Stage A: origin, integer parts and range check.
    logic [31:0]      ux_next, uy_next;
    logic [DIM_W-1:0] w_next, h_next;
    logic             in_next;

    always_comb begin
        ux_next = qx + origin_reg[31:0];
        uy_next = qy + origin_reg[63:32];
        w_next  = (geom_reg[15:0]  > MAX_DIM) ? MAX_DIM : geom_reg[15:0];
        h_next  = (geom_reg[31:16] > MAX_DIM) ? MAX_DIM : geom_reg[31:16];
        in_next = !dfl.bad_x && !dfl.bad_y && !ux_next[31] && !uy_next[31]
                  && (ux_next[31:16] < w_next) && (uy_next[31:16] < h_next);
    end

    logic             va_reg, lasta_reg, oka_reg;
    logic [DIM_W-1:0] ixa_reg, iya_reg;
    logic             vb_reg, lastb_reg, okb_reg;
    logic [DIM_W-1:0] ixb_reg;
    logic [31:0]      prodb_reg;

    logic [ADDRESS_BITS-1:0] addr_next;
    logic [31:0]             mdata_reg;
    logic                    mok_reg, mlast_reg;

    always_comb begin
        addr_next = ADDRESS_BITS'(base_reg) + ADDRESS_BITS'(prodb_reg)
                    + ADDRESS_BITS'(ixb_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else if (en) begin
            va_reg <= dv;
            vb_reg <= va_reg;
            mv_reg <= vb_reg;
        end
        if (en) begin
            lasta_reg <= dfl.last;
            oka_reg   <= in_next;
            ixa_reg   <= ux_next[31:16];
            iya_reg   <= uy_next[31:16];
            lastb_reg <= lasta_reg;
            okb_reg   <= oka_reg;
            ixb_reg   <= ixa_reg;
            prodb_reg <= 32'(iya_reg) * 32'(geom_reg[47:32]);
            mlast_reg <= lastb_reg;
            mok_reg   <= okb_reg;
            // An invalid pixel reports address zero.
            mdata_reg <= okb_reg ? 32'(addr_next) : 32'd0;
        end
    end

    assign m_axis_tvalid   = mv_reg;
    assign m_axis_tdata    = mdata_reg;
    assign m_axis_tuser[0] = mok_reg;
    assign m_axis_tlast    = mlast_reg;

endmodule

// ===== tb/psag_checker.sv =====
`timescale 1ns / 1ps
// Checker for the projective source address generator: watches both streams and config writes.
// Predicts each result from its own register copy; depends on psag_pkg.
module psag_checker import psag_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [31:0]          m_axis_tdata,
    input  logic [0:0]           m_axis_tuser,
    input  logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending_count
);
    localparam int MAX_DIM = 4096;

    typedef struct packed {
        logic [31:0] addr;
        logic        valid;
        logic        span_end;
    } pixel_res_t;

    logic [63:0] shadow_regs [8];
    pixel_res_t  expected_pixels [$];

    assign pending_count = expected_pixels.size();

    // Projects one coordinate; returns 0 on a zero divisor or quotient overflow.
    function automatic bit project_coord(input logic [31:0] num, input logic [31:0] den,
                                         input logic [31:0] origin,
                                         output longint ipart);
        longint n, d, q;
        logic [31:0] s;
        n = longint'($signed(num)) * 65536;
        d = longint'($signed(den));
        if (d == 0) return 0;
        q = n / d;
        if (q > 64'sd2147483647 || q < -64'sd2147483648) return 0;
        s = q[31:0] + origin;
        ipart = longint'($signed(s)) >>> 16;
        return 1;
    endfunction

    function automatic pixel_res_t map_pixel(input logic [11:0] x, input logic [11:0] y,
                                             input logic last);
        logic [31:0] sx, sy, sz, xx, yy;
        longint ix, iy;
        longint unsigned w, h, p;
        bit okx, oky, ok;
        pixel_res_t r;
        xx = {20'd0, x};
        yy = {20'd0, y};
        sx = shadow_regs[0][31:0] * xx + shadow_regs[0][63:32] * yy + shadow_regs[3][31:0];
        sy = shadow_regs[1][31:0] * xx + shadow_regs[1][63:32] * yy + shadow_regs[3][63:32];
        sz = shadow_regs[2][31:0] * xx + shadow_regs[2][63:32] * yy + shadow_regs[4][31:0];
        w = shadow_regs[6][15:0];
        h = shadow_regs[6][31:16];
        p = shadow_regs[6][47:32];
        if (w > MAX_DIM) w = MAX_DIM;
        if (h > MAX_DIM) h = MAX_DIM;
        okx = project_coord(sx, sz, shadow_regs[5][31:0], ix);
        oky = project_coord(sy, sz, shadow_regs[5][63:32], iy);
        ok = okx && oky;
        if (ok) ok = ix >= 0 && iy >= 0 && ix < longint'(w) && iy < longint'(h);
        r.addr = '0;
        if (ok) r.addr = shadow_regs[7][31:0] + 32'(longint'(iy) * p) + 32'(ix);
        r.valid = ok;
        r.span_end = last;
        return r;
    endfunction

    always @(posedge aclk) begin
        pixel_res_t want;
        if (!aresetn) begin
            shadow_regs[0] <= 64'd65536;
            shadow_regs[1] <= 64'd281474976710656;
            shadow_regs[2] <= '0;
            shadow_regs[3] <= '0;
            shadow_regs[4] <= 64'd65536;
            shadow_regs[5] <= '0;
            shadow_regs[6] <= '0;
            shadow_regs[7] <= '0;
            fail_count <= 0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_Z_OFFSET, REG_SOURCE_BASE: shadow_regs[cfg_index] <= {32'd0, cfg_data[31:0]};
                    REG_SOURCE_GEOMETRY: shadow_regs[cfg_index] <= {16'd0, cfg_data[47:0]};
                    default: shadow_regs[cfg_index] <= cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(map_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12],
                                                    s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result addr=%h valid=%b last=%b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.addr !== m_axis_tdata || want.valid !== m_axis_tuser[0] ||
                        want.span_end !== m_axis_tlast) begin
                        $display("%0t: mismatch expected addr=%h valid=%b last=%b, got addr=%h valid=%b last=%b",
                                 $time, want.addr, want.valid, want.span_end,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for projective_source_address_gen: clock, reset, stimulus and verdict.
// Depends on psag_pkg, psag_checker and the block itself.
module tb_top;
    import psag_pkg::*;

    localparam int LATENCY = 56;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic                 s_axis_tlast = 0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [31:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int                   fail_count, pending_count;
    int                   idle_cycles;

    projective_source_address_gen u_top (.*);
    psag_checker u_chk (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Receiver stalls a random number of cycles before each item, often none.
    always @(posedge aclk) begin
        int wait_cnt;
        if (!aresetn) begin
            m_axis_tready <= 0;
            wait_cnt = 0;
        end else if (wait_cnt > 0) begin
            wait_cnt--;
            m_axis_tready <= 0;
        end else if (m_axis_tready && m_axis_tvalid) begin
            wait_cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            m_axis_tready <= (wait_cnt == 0);
        end else begin
            m_axis_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("projective_source_address_gen verification failed");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        // Waiting with cfg_valid low keeps the next write in a later time step.
        @(posedge aclk);
    endtask

    task automatic drain_pixels();
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic last,
                              input bit may_gap);
        int gap;
        gap = (may_gap && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata <= {y, x};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'(int'($urandom_range(0, 8192)) - 4096);
            4: return 32'(int'($urandom_range(0, 262144)) - 131072);
            default: return 32'(int'($urandom_range(0, 65536 * 8)) - 65536 * 4);
        endcase
    endfunction

    task automatic random_setting();
        logic [15:0] w, h;
        w = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        h = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        write_reg(REG_X_ROW_SCALES, {rand_coef(), rand_coef()});
        write_reg(REG_Y_ROW_SCALES, {rand_coef(), rand_coef()});
        // A small z row keeps the divisor sign and size varied without always overflowing.
        write_reg(REG_Z_ROW_SCALES, ($urandom_range(0, 3) == 0) ? 64'd0 :
                  {32'(int'($urandom_range(0, 64)) - 32), 32'(int'($urandom_range(0, 64)) - 32)});
        write_reg(REG_XY_OFFSETS, {rand_coef(), rand_coef()});
        write_reg(REG_Z_OFFSET, ($urandom_range(0, 5) == 0) ? 64'd0 :
                  {$urandom, 32'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536)});
        write_reg(REG_ORIGIN_OFFSETS, {rand_coef(), rand_coef()});
        write_reg(REG_SOURCE_GEOMETRY, {16'($urandom), 16'($urandom), h, w});
        write_reg(REG_SOURCE_BASE, {$urandom, $urandom});
    endtask

    initial begin
        logic [11:0] x0, y0;
        int len;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Reset values map identity onto an empty source: every pixel is outside.
        send_pixel(0, 0, 1, 0);
        send_pixel(12'hfff, 12'hfff, 0, 0);
        end_burst();
        drain_pixels();

        // Identity mapping onto a large source, at the width clamp and beyond.
        write_reg(REG_SOURCE_GEOMETRY, {16'd0, 16'hffff, 16'd5000, 16'd5000});
        write_reg(REG_SOURCE_BASE, 64'hffff_ffff_ffff_f000);
        send_pixel(0, 0, 0, 0);
        send_pixel(12'hfff, 0, 1, 0);
        send_pixel(0, 12'hfff, 0, 0);
        send_pixel(12'hfff, 12'hfff, 1, 0);
        end_burst();
        drain_pixels();
        // Origin wrap and negative parts.
        write_reg(REG_ORIGIN_OFFSETS, {32'h7fff_0000, 32'hffff_0000});
        send_pixel(1, 1, 0, 0);
        send_pixel(12'h800, 12'h123, 1, 0);
        end_burst();
        drain_pixels();
        // Zero divisor.
        write_reg(REG_Z_OFFSET, 64'hffff_ffff_0000_0000);
        send_pixel(5, 5, 1, 0);
        end_burst();
        drain_pixels();
        // Quotient overflow: tiny divisor.
        write_reg(REG_Z_OFFSET, 64'd1);
        write_reg(REG_ORIGIN_OFFSETS, 64'd0);
        send_pixel(100, 100, 0, 0);
        send_pixel(0, 0, 1, 0);
        end_burst();
        drain_pixels();
        // Negative divisor and extreme coefficients.
        write_reg(REG_Z_OFFSET, 64'hffff_0000);
        write_reg(REG_X_ROW_SCALES, {32'h8000_0000, 32'h7fff_ffff});
        write_reg(REG_Y_ROW_SCALES, {32'hffff_ffff, 32'h8000_0000});
        write_reg(REG_XY_OFFSETS, {32'h7fff_ffff, 32'h8000_0000});
        write_reg(REG_Z_ROW_SCALES, {32'hffff_ffff, 32'h0000_0001});
        send_pixel(0, 0, 0, 0);
        send_pixel(12'hfff, 12'hfff, 1, 0);
        send_pixel(12'h555, 12'haaa, 0, 0);
        end_burst();
        drain_pixels();

        // Random phases: spans across rows, with gaps and a full drain between settings.
        for (int ph = 0; ph < 30; ph++) begin
            random_setting();
            for (int sp = 0; sp < 8; sp++) begin
                len = $urandom_range(1, 16);
                x0 = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
                y0 = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
                for (int k = 0; k < len; k++)
                    send_pixel(x0 + 12'(k), y0, k == len - 1, ph % 3 != 0);
            end
            end_burst();
            drain_pixels();
        end
        if (fail_count == 0)
            $display("projective_source_address_gen verification clean");
        else
            $display("projective_source_address_gen verification failed");
        $finish;
    end
endmodule
